FILE: rtl/aom_pkg.sv
// Shared types and constants for the audio overlay mixer.
`default_nettype none

package aom_pkg;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 16;
    localparam int COUNT_W  = 32;
    localparam int SUM_W    = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(32768);

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(4096);
    localparam logic [GAIN_W-1:0] PAN_RESET  = GAIN_W'(23170);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OVERLAY_GAIN = 2'd0,
        CFG_PAN_LEFT     = 2'd1,
        CFG_PAN_RIGHT    = 2'd2,
        CFG_MIX_MODE     = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_STEREO  = 2'd0,
        MODE_MONO    = 2'd1,
        MODE_PAN     = 2'd2,
        MODE_DOWNMIX = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GAIN_L,
        S_GAIN_R,
        S_PAN_L,
        S_PAN_R,
        S_SUM
    } t_state;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] base_left;
        logic signed [SAMPLE_W-1:0] base_right;
        logic signed [SAMPLE_W-1:0] overlay_left;
        logic signed [SAMPLE_W-1:0] overlay_right;
        logic                       overlay_present;
    } t_frame;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mixed_left;
        logic signed [SAMPLE_W-1:0] mixed_right;
        logic                       left_clipped;
        logic                       right_clipped;
        logic [COUNT_W-1:0]         clip_total;
    } t_mix;

    typedef struct packed {
        logic [GAIN_W-1:0] overlay_gain;
        logic [GAIN_W-1:0] pan_left_gain;
        logic [GAIN_W-1:0] pan_right_gain;
        t_mode             mix_mode;
    } t_cfg;

    // classified frame handed from front to back
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] base_l;
        logic signed [SAMPLE_W-1:0] base_r;
        logic signed [SAMPLE_W-1:0] ovl_a;
        logic signed [SAMPLE_W-1:0] ovl_b;
        logic                       present;
        logic                       pan;
        logic                       stereo;
    } t_job;

endpackage

`default_nettype wire

FILE: rtl/audio_overlay_mixer_top.sv
// Top level of the audio overlay mixer: config registers, front end, queue, mix engine.
//
//  channel   direction  handshake           payload
//  frame     in         push / full         i_frame (t_frame)
//  mix       out        empty / pop         o_mix   (t_mix)
//  config    in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// Engine states: IDLE, SUM without overlay; plus GAIN_L in mono/downmix, GAIN_L, GAIN_R in
// stereo, GAIN_L, PAN_L, PAN_R in pan mode; the single shared 33x17 multiplier sets this.
// Front register and two-entry queue add latency but let requests enter while the
// engine works. Reset is synchronous, active low, and clears control state and the
// clip counter. A held result stalls the engine in its final step only.
`default_nettype none

module audio_overlay_mixer_top (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         push,
    output logic                        full,
    input  wire aom_pkg::t_frame        i_frame,
    output logic                        empty,
    input  wire                         pop,
    output aom_pkg::t_mix               o_mix,
    input  wire                         i_cfg_we,
    input  wire [aom_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire [aom_pkg::GAIN_W-1:0]   i_cfg_data
);
    import aom_pkg::*;

    t_cfg r_cfg;
    logic f_valid;
    t_job f_job;
    logic q_full;
    logic q_valid;
    t_job q_job;
    logic q_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.overlay_gain   <= GAIN_RESET;
            r_cfg.pan_left_gain  <= PAN_RESET;
            r_cfg.pan_right_gain <= PAN_RESET;
            r_cfg.mix_mode       <= MODE_STEREO;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_OVERLAY_GAIN: r_cfg.overlay_gain   <= i_cfg_data;
                CFG_PAN_LEFT:     r_cfg.pan_left_gain  <= i_cfg_data;
                CFG_PAN_RIGHT:    r_cfg.pan_right_gain <= i_cfg_data;
                CFG_MIX_MODE:     r_cfg.mix_mode       <= t_mode'(i_cfg_data[1:0]);
                default:          r_cfg.mix_mode       <= r_cfg.mix_mode;
            endcase
        end
    end

    aom_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .push        (push),
        .full        (full),
        .i_frame     (i_frame),
        .o_job_valid (f_valid),
        .o_job       (f_job),
        .i_job_full  (q_full)
    );

    aom_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (f_valid),
        .i_wr_job (f_job),
        .o_full   (q_full),
        .o_valid  (q_valid),
        .o_rd_job (q_job),
        .i_rd     (q_rd)
    );

    aom_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_job   (q_job),
        .o_q_rd    (q_rd),
        .empty     (empty),
        .pop       (pop),
        .o_mix     (o_mix)
    );

    // a flagged clip must show a rail value
    a_left_clip_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_mix.left_clipped) |->
            (o_mix.mixed_left == 16'sd32767 || o_mix.mixed_left == -16'sd32768))
        else $error("left clip flag without rail value");

    a_right_clip_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_mix.right_clipped) |->
            (o_mix.mixed_right == 16'sd32767 || o_mix.mixed_right == -16'sd32768))
        else $error("right clip flag without rail value");

    a_clip_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_mix.left_clipped || o_mix.right_clipped)) |->
            (o_mix.clip_total != '0))
        else $error("clip not counted");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result pending after reset");

endmodule

`default_nettype wire

FILE: rtl/aom_front.sv
// Front end: takes a frame, classifies it by mix mode and registers the job.
`default_nettype none

module aom_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire aom_pkg::t_cfg  i_cfg,
    input  wire                 push,
    output logic                full,
    input  wire aom_pkg::t_frame i_frame,
    output logic                o_job_valid,
    output aom_pkg::t_job       o_job,
    input  wire                 i_job_full
);
    import aom_pkg::*;

    logic                    r_valid;
    t_job                    r_job;
    t_job                    n_job;
    logic signed [SAMPLE_W:0] ovl_sum;
    logic signed [SAMPLE_W:0] ovl_rnd;
    logic                    take;
    logic                    hand_off;

    // average truncated toward zero: add one before the shift when negative
    assign ovl_sum = (SAMPLE_W+1)'(i_frame.overlay_left) + (SAMPLE_W+1)'(i_frame.overlay_right);
    assign ovl_rnd = ovl_sum + $signed({{SAMPLE_W{1'b0}}, ovl_sum[SAMPLE_W]});

    always_comb begin
        n_job.base_l  = i_frame.base_left;
        n_job.base_r  = i_frame.base_right;
        n_job.ovl_a   = (i_cfg.mix_mode == MODE_DOWNMIX) ? ovl_rnd[SAMPLE_W:1]
                                                         : i_frame.overlay_left;
        n_job.ovl_b   = i_frame.overlay_right;
        n_job.present = i_frame.overlay_present;
        n_job.pan     = (i_cfg.mix_mode == MODE_PAN);
        n_job.stereo  = (i_cfg.mix_mode == MODE_STEREO) || (i_cfg.mix_mode == MODE_PAN);
    end

    assign hand_off    = r_valid && !i_job_full;
    assign full        = r_valid && i_job_full;
    assign take        = push && !full;
    assign o_job_valid = r_valid;
    assign o_job       = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (hand_off) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job <= n_job;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/aom_queue.sv
// Two-entry job queue between front end and mix engine.
`default_nettype none

module aom_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_wr,
    input  wire aom_pkg::t_job i_wr_job,
    output logic            o_full,
    output logic            o_valid,
    output aom_pkg::t_job   o_rd_job,
    input  wire             i_rd
);
    import aom_pkg::*;

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_wr;
    logic       do_rd;

    assign o_full   = (r_count == 2'd2);
    assign o_valid  = (r_count != 2'd0);
    assign o_rd_job = r_mem[r_rd_ptr];
    assign do_wr    = i_wr && !o_full;
    assign do_rd    = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_rd) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({do_wr, do_rd})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_job;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/aom_back.sv
// Mix engine: shared multiplier sequencer, floor/saturate, clip counter, result register.
`default_nettype none

module aom_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire aom_pkg::t_cfg i_cfg,
    input  wire              i_q_valid,
    input  wire aom_pkg::t_job i_q_job,
    output logic             o_q_rd,
    output logic             empty,
    input  wire              pop,
    output aom_pkg::t_mix    o_mix
);
    import aom_pkg::*;

    t_state                   r_state;
    t_state                   n_state;
    t_job                     r_job;
    logic signed [32:0]       r_gl;
    logic signed [32:0]       r_gr;
    logic signed [49:0]       r_tl;
    logic signed [49:0]       r_tr;
    logic                     r_out_valid;
    t_mix                     r_out;
    logic [COUNT_W-1:0]       r_clip_cnt;

    logic signed [32:0]       mul_a;
    logic signed [16:0]       mul_b;
    logic signed [49:0]       mul_p;
    logic                     ld_gl;
    logic                     ld_gr;
    logic                     ld_tl;
    logic                     ld_tr;
    logic                     commit;

    logic signed [SUM_W-1:0]  term_l;
    logic signed [SUM_W-1:0]  term_r;
    logic signed [SUM_W-1:0]  sum_l;
    logic signed [SUM_W-1:0]  sum_r;
    logic                     lc;
    logic                     rc;
    logic signed [SAMPLE_W-1:0] sat_l;
    logic signed [SAMPLE_W-1:0] sat_r;
    logic [1:0]               inc;
    logic [COUNT_W:0]         cnt_sum;
    logic [COUNT_W-1:0]       n_clip_cnt;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_state = i_q_job.present ? S_GAIN_L : S_SUM;
                end
            end
            S_GAIN_L: begin
                priority if (r_job.pan)    n_state = S_PAN_L;
                else if (r_job.stereo)     n_state = S_GAIN_R;
                else                       n_state = S_SUM;
            end
            S_GAIN_R: n_state = S_SUM;
            S_PAN_L:  n_state = S_PAN_R;
            S_PAN_R:  n_state = S_SUM;
            S_SUM: begin
                if (!r_out_valid || pop) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        o_q_rd = 1'b0;
        ld_gl  = 1'b0;
        ld_gr  = 1'b0;
        ld_tl  = 1'b0;
        ld_tr  = 1'b0;
        commit = 1'b0;
        mul_a  = 33'(r_job.ovl_a);
        mul_b  = $signed({1'b0, i_cfg.overlay_gain});
        unique case (r_state)
            S_IDLE:   o_q_rd = i_q_valid;
            S_GAIN_L: ld_gl  = 1'b1;
            S_GAIN_R: begin
                ld_gr = 1'b1;
                mul_a = 33'(r_job.ovl_b);
            end
            S_PAN_L: begin
                ld_tl = 1'b1;
                mul_a = r_gl;
                mul_b = $signed({1'b0, i_cfg.pan_left_gain});
            end
            S_PAN_R: begin
                ld_tr = 1'b1;
                mul_a = r_gl;
                mul_b = $signed({1'b0, i_cfg.pan_right_gain});
            end
            S_SUM:    commit = !r_out_valid || pop;
            default:  o_q_rd = 1'b0;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // floor of product / 2^k is the arithmetic shift
    always_comb begin
        if (!r_job.present) begin
            term_l = '0;
            term_r = '0;
        end else if (r_job.pan) begin
            term_l = SUM_W'($signed(r_tl[49:27]));
            term_r = SUM_W'($signed(r_tr[49:27]));
        end else begin
            term_l = SUM_W'($signed(r_gl[32:12]));
            term_r = SUM_W'($signed(r_gr[32:12]));
        end
        sum_l = SUM_W'(r_job.base_l) + term_l;
        sum_r = SUM_W'(r_job.base_r) + term_r;

        lc    = (sum_l > SAT_MAX) || (sum_l < SAT_MIN);
        sat_l = (sum_l > SAT_MAX) ? SAT_MAX[SAMPLE_W-1:0] :
                (sum_l < SAT_MIN) ? SAT_MIN[SAMPLE_W-1:0] : sum_l[SAMPLE_W-1:0];
        if (r_job.stereo) begin
            rc    = (sum_r > SAT_MAX) || (sum_r < SAT_MIN);
            sat_r = (sum_r > SAT_MAX) ? SAT_MAX[SAMPLE_W-1:0] :
                    (sum_r < SAT_MIN) ? SAT_MIN[SAMPLE_W-1:0] : sum_r[SAMPLE_W-1:0];
        end else begin
            rc    = 1'b0;
            sat_r = '0;
        end

        inc        = {1'b0, lc} + {1'b0, rc};
        cnt_sum    = {1'b0, r_clip_cnt} + (COUNT_W+1)'(inc);
        n_clip_cnt = cnt_sum[COUNT_W] ? {COUNT_W{1'b1}} : cnt_sum[COUNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_clip_cnt  <= '0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_out_valid <= 1'b1;
                r_clip_cnt  <= n_clip_cnt;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_job <= i_q_job;
        end
        if (ld_gl) begin
            r_gl <= mul_p[32:0];
        end
        if (ld_gr) begin
            r_gr <= mul_p[32:0];
        end
        if (ld_tl) begin
            r_tl <= mul_p;
        end
        if (ld_tr) begin
            r_tr <= mul_p;
        end
        if (commit) begin
            r_out.mixed_left    <= sat_l;
            r_out.mixed_right   <= sat_r;
            r_out.left_clipped  <= lc;
            r_out.right_clipped <= rc;
            r_out.clip_total    <= n_clip_cnt;
        end
    end

    assign empty = !r_out_valid;
    assign o_mix = r_out;

endmodule

`default_nettype wire
